// ===== rtl/rcaf_pkg.sv =====
// ----------------------------------------------------------------------------
// rcaf_pkg
// Shared types and constants for the RC channel averaging filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rcaf_pkg;

  localparam int unsigned CHANNELS_DEF = 6;
  localparam int unsigned FIELD_COUNT  = 6;
  localparam int unsigned VAL_W        = 12;
  localparam int unsigned HIST_DEPTH   = 4;
  localparam int unsigned SLOT_W       = $clog2(HIST_DEPTH);
  localparam int unsigned SUM_W        = VAL_W + SLOT_W;

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [SLOT_W-1:0] slot_t;

  localparam val_t HELD_RESET = val_t'(1500);
  localparam val_t DEADBAND   = val_t'(3);
  localparam val_t STEP_BACK  = val_t'(2);

  typedef struct packed {
    logic  adv;
    logic  bypass;
    slot_t slot;
  } chan_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/rcaf_in_if.sv =====
// ----------------------------------------------------------------------------
// rcaf_in_if
// Input channel: one frame of six raw pulse widths per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcaf_in_if import rcaf_pkg::*; ();
  logic valid;
  logic ready;
  val_t raw_ch0;
  val_t raw_ch1;
  val_t raw_ch2;
  val_t raw_ch3;
  val_t raw_ch4;
  val_t raw_ch5;

  modport source (
    output valid, raw_ch0, raw_ch1, raw_ch2, raw_ch3, raw_ch4, raw_ch5,
    input  ready
  );
  modport sink (
    input  valid, raw_ch0, raw_ch1, raw_ch2, raw_ch3, raw_ch4, raw_ch5,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/rcaf_out_if.sv =====
// ----------------------------------------------------------------------------
// rcaf_out_if
// Result channel: six held filtered values per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcaf_out_if import rcaf_pkg::*; ();
  logic valid;
  logic ready;
  val_t filt_ch0;
  val_t filt_ch1;
  val_t filt_ch2;
  val_t filt_ch3;
  val_t filt_ch4;
  val_t filt_ch5;

  modport source (
    output valid, filt_ch0, filt_ch1, filt_ch2, filt_ch3, filt_ch4, filt_ch5,
    input  ready
  );
  modport sink (
    input  valid, filt_ch0, filt_ch1, filt_ch2, filt_ch3, filt_ch4, filt_ch5,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/rc_channel_averaging_filter.sv =====
// ----------------------------------------------------------------------------
// rc_channel_averaging_filter
// Four-sample moving average with deadband over six RC pulse widths.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one item per receiver frame, six raw 12-bit pulse widths.
//   out_ch : one item per input item, six held filtered values.
//   cfg_we / cfg_wdata : bypass_mode, written while the block is idle.
// An item is registered at the input, then the per-channel sum, mean and
// deadband logic feeds the result register, which raises out_ch.valid.
// One item per cycle is sustained while out_ch.ready stays high; the limit is
// the single history update per channel each cycle.
// Reset clears history to zero, slot index to zero, held values to 1500 and
// bypass off; both stages empty.
// When the receiver stalls, the result register holds its item and the input
// register can still take one more; in_ch.ready drops only while both are
// full and out_ch.ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_channel_averaging_filter import rcaf_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  rcaf_in_if.sink     in_ch,
  rcaf_out_if.source  out_ch,
  input  wire         cfg_we,
  input  wire         cfg_wdata
);

  logic       bypass_r;
  slot_t      slot_r;
  logic       s1_valid_r;
  val_t       s1_raw_r [FIELD_COUNT];
  logic       out_valid_r;
  val_t       filt_r   [FIELD_COUNT];
  logic       advance;
  chan_ctrl_t ctrl;
  val_t       held_nxt [CHANNELS];

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  assign ctrl.adv    = advance;
  assign ctrl.bypass = bypass_r;
  assign ctrl.slot   = slot_r + slot_t'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r    <= 1'b0;
      slot_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        bypass_r <= cfg_wdata;
      end
      if (advance && !bypass_r) begin
        slot_r <= ctrl.slot;
      end
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_raw_r[0] <= in_ch.raw_ch0;
      s1_raw_r[1] <= in_ch.raw_ch1;
      s1_raw_r[2] <= in_ch.raw_ch2;
      s1_raw_r[3] <= in_ch.raw_ch3;
      s1_raw_r[4] <= in_ch.raw_ch4;
      s1_raw_r[5] <= in_ch.raw_ch5;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    val_t raw;
    if (c < FIELD_COUNT) begin : g_raw
      assign raw = s1_raw_r[c];
    end else begin : g_zero
      assign raw = '0;
    end

    rcaf_chan u_chan (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .raw      (raw),
      .held_nxt (held_nxt[c])
    );
  end

  for (genvar f = 0; f < FIELD_COUNT; f++) begin : g_field
    if (f < CHANNELS) begin : g_live
      always_ff @(posedge clk) begin
        if (advance) begin
          filt_r[f] <= held_nxt[f];
        end
      end
    end else begin : g_fixed
      always_ff @(posedge clk) begin
        filt_r[f] <= HELD_RESET;
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.filt_ch0 = filt_r[0];
  assign out_ch.filt_ch1 = filt_r[1];
  assign out_ch.filt_ch2 = filt_r[2];
  assign out_ch.filt_ch3 = filt_r[3];
  assign out_ch.filt_ch4 = filt_r[4];
  assign out_ch.filt_ch5 = filt_r[5];

endmodule

`default_nettype wire

// ===== rtl/rcaf_chan.sv =====
// ----------------------------------------------------------------------------
// rcaf_chan
// One channel: four-entry history, rounded mean and deadband on held value.
// ----------------------------------------------------------------------------
`default_nettype none

module rcaf_chan import rcaf_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  chan_ctrl_t ctrl,
  input  val_t       raw,
  output val_t       held_nxt
);

  val_t hist_r [HIST_DEPTH];
  val_t held_r;

  logic [SUM_W-1:0] sum;
  val_t             mean;
  logic [VAL_W:0]   held_x;
  logic [VAL_W:0]   mean_x;

  always_comb begin
    sum = '0;
    for (int unsigned a = 0; a < HIST_DEPTH; a++) begin
      if (slot_t'(a) == ctrl.slot) begin
        sum = sum + SUM_W'(raw);
      end else begin
        sum = sum + SUM_W'(hist_r[a]);
      end
    end
  end

  assign mean   = val_t'((sum + SUM_W'(HIST_DEPTH / 2)) >> SLOT_W);
  assign held_x = {1'b0, held_r};
  assign mean_x = {1'b0, mean};

  always_comb begin
    held_nxt = held_r;
    if (ctrl.bypass) begin
      held_nxt = raw;
    end else if (held_r >= DEADBAND && mean_x < held_x - {1'b0, DEADBAND}) begin
      held_nxt = mean + STEP_BACK;
    end else if (mean_x > held_x + {1'b0, DEADBAND}) begin
      held_nxt = mean - STEP_BACK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= HELD_RESET;
      for (int unsigned a = 0; a < HIST_DEPTH; a++) begin
        hist_r[a] <= '0;
      end
    end else if (ctrl.adv) begin
      held_r <= held_nxt;
      if (!ctrl.bypass) begin
        hist_r[ctrl.slot] <= raw;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rcaf_checker.sv =====
// ----------------------------------------------------------------------------
// rcaf_checker
// Port-level checks on the RC channel averaging filter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rcaf_checker import rcaf_pkg::*; (
  input wire  clk,
  input wire  rst_n,
  input wire  in_valid,
  input wire  in_ready,
  input wire  out_valid,
  input wire  out_ready,
  input val_t filt_ch0,
  input val_t filt_ch5
);

  // result stage empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input only backs up when the result side is stalled
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output stall");

  // result valid is raised behind every accepted item
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> ##1 out_valid)
    else $error("result missing after accepted item");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(filt_ch0) && $stable(filt_ch5)))
    else $error("stalled result changed");

endmodule

bind rc_channel_averaging_filter rcaf_checker u_rcaf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .filt_ch0  (out_ch.filt_ch0),
  .filt_ch5  (out_ch.filt_ch5)
);

`default_nettype wire
